// ----- src/idll_pkg.sv -----
// Shared types and codes for the indexed doubly linked list block.
// Used by the controller, the datapath and the top level; depends on nothing.
package idll_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DUMP      = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Read address select for the node memories
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_FREE = 2'd0;
    localparam rd_sel_t RD_HEAD = 2'd1;
    localparam rd_sel_t RD_WALK = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic                clr;
        logic                load;
        logic                pop;
        logic                link;
        logic                del;
        logic                emit;
        logic                respond;
        logic [STATUS_W-1:0] resp_status;
        rd_sel_t             rd_sel;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic head_null;
        logic free_null;
        logic clr_last;
        logic last;
    } stat_t;

endpackage

// ----- src/indexed_doubly_linked_list.sv -----
// Indexed doubly linked list: a store of NODE_COUNT nodes kept as a list plus a free
// chain, taking insert at front, insert at end, delete front and dump requests. After
// reset the block runs a clearing pass over the NODE_COUNT nodes that builds the free
// chain (req_ready stays low meanwhile). A tail pointer makes both inserts constant
// time: an insert pops a node off the free chain, then links it; a delete unlinks the
// head; a full store or empty list is answered straight from idle. A dump reads one
// node per stored value and hands each out through the result register handshake
// before reading the next. Items are worked one at a time; each result word waits
// in an output register until taken. Depends on idll_pkg, idll_ctrl, idll_dp and idll_ram.
module indexed_doubly_linked_list #(
    parameter int NODE_COUNT = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [idll_pkg::MODE_W-1:0]           mode,
    input  logic signed [idll_pkg::DATA_W-1:0]    value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [idll_pkg::STATUS_W-1:0]         status,
    output logic signed [idll_pkg::DATA_W-1:0]    item,
    output logic                                  last
);
    import idll_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    idll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .mode      (mode),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    idll_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .mode   (mode),
        .value  (value),
        .status (status),
        .item   (item),
        .last   (last)
    );

endmodule

// ----- src/idll_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// Standalone; used for the node value, back link and forward link stores.
module idll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/idll_dp.sv -----
// Datapath: node memories, list and free-chain pointers, walk state and result word.
// Depends on idll_pkg and idll_ram; driven by commands from idll_ctrl.
module idll_dp #(
    parameter int NODE_COUNT = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  idll_pkg::cmd_t                        cmd,
    output idll_pkg::stat_t                       stat,
    input  logic [idll_pkg::MODE_W-1:0]           mode,
    input  logic signed [idll_pkg::DATA_W-1:0]    value,
    output logic [idll_pkg::STATUS_W-1:0]         status,
    output logic signed [idll_pkg::DATA_W-1:0]    item,
    output logic                                  last
);
    import idll_pkg::*;

    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam int AW = $clog2(NODE_COUNT);
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     tail_reg, tail_next;
    logic [LW-1:0]     free_head_reg, free_head_next;
    logic [LW-1:0]     walk_reg, walk_next;
    logic [LW-1:0]     count_reg, count_next;
    logic [AW-1:0]     clr_idx_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] value_reg;
    logic [LW-1:0]     node_reg;
    logic [LW-1:0]     link_reg;

    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] val_rd;
    logic [LW-1:0]     fwd_rd;
    logic [LW-1:0]     back_rd;

    logic              val_we, fwd_we, back_we;
    logic [AW-1:0]     val_waddr, fwd_waddr, back_waddr;
    logic [LW-1:0]     fwd_wdata, back_wdata;

    logic [LW-1:0]     nx;
    logic              nx_is_node;
    logic              head_null, free_null, link_is_node, fin;

    assign head_null    = (head_reg >= NULL_LINK);
    assign free_null    = (free_head_reg >= NULL_LINK);
    assign link_is_node = (link_reg < NULL_LINK);
    assign nx_is_node   = (fwd_rd < NULL_LINK);
    assign nx           = nx_is_node ? fwd_rd : NULL_LINK;
    assign fin          = !nx_is_node || (count_reg == LW'(NODE_COUNT - 1));

    assign stat.head_null = head_null;
    assign stat.free_null = free_null;
    assign stat.clr_last  = (clr_idx_reg == AW'(NODE_COUNT - 1));
    assign stat.last      = last;

    // Select the node read by all three memories
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FREE: raddr = free_head_reg[AW-1:0];
            RD_HEAD: raddr = head_reg[AW-1:0];
            default: raddr = walk_reg[AW-1:0];
        endcase
    end

    // Value store writes
    assign val_we    = cmd.pop;
    assign val_waddr = free_head_reg[AW-1:0];

    // Forward link writes: clearing pass, new node, tail append, freed head
    always_comb
    begin
        fwd_we    = 1'b0;
        fwd_waddr = clr_idx_reg;
        fwd_wdata = LW'(clr_idx_reg) + LW'(1);
        if (cmd.clr)
        begin
            fwd_we = 1'b1;
        end
        else if (cmd.pop)
        begin
            fwd_we    = 1'b1;
            fwd_waddr = free_head_reg[AW-1:0];
            fwd_wdata = (mode_reg == MODE_INS_FRONT) ? head_reg : NULL_LINK;
        end
        else if (cmd.link && mode_reg == MODE_INS_END && link_is_node)
        begin
            fwd_we    = 1'b1;
            fwd_waddr = link_reg[AW-1:0];
            fwd_wdata = node_reg;
        end
        else if (cmd.del)
        begin
            fwd_we    = 1'b1;
            fwd_waddr = head_reg[AW-1:0];
            fwd_wdata = free_head_reg;
        end
    end

    // Back link writes: new node, old head, new head after delete
    always_comb
    begin
        back_we    = 1'b0;
        back_waddr = free_head_reg[AW-1:0];
        back_wdata = NULL_LINK;
        if (cmd.pop)
        begin
            back_we    = 1'b1;
            back_wdata = (mode_reg == MODE_INS_FRONT || head_null) ? NULL_LINK : tail_reg;
        end
        else if (cmd.link && mode_reg == MODE_INS_FRONT && link_is_node)
        begin
            back_we    = 1'b1;
            back_waddr = link_reg[AW-1:0];
            back_wdata = node_reg;
        end
        else if (cmd.del && nx_is_node)
        begin
            back_we    = 1'b1;
            back_waddr = nx[AW-1:0];
        end
    end

    idll_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (value_reg),
        .raddr (raddr),
        .rdata (val_rd)
    );

    idll_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (raddr),
        .rdata (fwd_rd)
    );

    idll_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (raddr),
        .rdata (back_rd)
    );

    // Pointer and walk updates
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        walk_next      = walk_reg;
        count_next     = count_reg;
        if (cmd.load)
        begin
            walk_next  = head_reg;
            count_next = '0;
        end
        if (cmd.pop)
        begin
            free_head_next = nx;
            if (mode_reg == MODE_INS_FRONT || head_null)
            begin
                head_next = free_head_reg;
            end
            if (mode_reg == MODE_INS_END || head_null)
            begin
                tail_next = free_head_reg;
            end
        end
        if (cmd.del)
        begin
            head_next      = nx;
            free_head_next = head_reg;
            if (!nx_is_node)
            begin
                tail_next = NULL_LINK;
            end
        end
        if (cmd.emit)
        begin
            walk_next  = nx;
            count_next = count_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NULL_LINK;
            tail_reg      <= NULL_LINK;
            free_head_reg <= '0;
            walk_reg      <= NULL_LINK;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            walk_reg      <= walk_next;
            count_reg     <= count_next;
            if (cmd.clr)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
        end
    end

    // Latch the input word, the node taken and its neighbor, and the result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        if (cmd.pop)
        begin
            node_reg <= free_head_reg;
            link_reg <= (mode_reg == MODE_INS_FRONT) ? head_reg :
                        (head_null ? NULL_LINK : tail_reg);
        end
        if (cmd.respond)
        begin
            status <= cmd.resp_status;
            item   <= '0;
            last   <= 1'b1;
        end
        else if (cmd.emit)
        begin
            status <= STAT_OK;
            item   <= val_rd;
            last   <= fin;
        end
    end

    // Head and tail are empty together
    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg >= NULL_LINK) == (tail_reg >= NULL_LINK))
        else $error("head and tail disagree on empty list");

    // The list head is never also the head of the free chain
    a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
        !head_null |-> head_reg != free_head_reg)
        else $error("list head equals free head");

    // The first node of a dump has no back link
    a_head_back: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && count_reg == '0 |-> back_rd == NULL_LINK)
        else $error("head node has a back link");

endmodule

// ----- src/idll_ctrl.sv -----
// Controller state machine: dispatch on mode, sequence memory steps, hold results.
// Depends on idll_pkg; drives the command struct of idll_dp.
module idll_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [idll_pkg::MODE_W-1:0] mode,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output idll_pkg::cmd_t              cmd,
    input  idll_pkg::stat_t             stat
);
    import idll_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_DEL   = 3'd4;
    localparam logic [2:0] S_DUMP  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_WALK;
        cmd.resp_status = STAT_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (mode) inside
                        MODE_INS_FRONT, MODE_INS_END:
                        begin
                            if (stat.free_null)
                            begin
                                cmd.respond     = 1'b1;
                                cmd.resp_status = STAT_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                cmd.rd_sel = RD_FREE;
                                state_next = S_POP;
                            end
                        end
                        MODE_DEL_FRONT, MODE_DUMP:
                        begin
                            if (stat.head_null)
                            begin
                                cmd.respond     = 1'b1;
                                cmd.resp_status = STAT_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                cmd.rd_sel = RD_HEAD;
                                state_next = (mode == MODE_DUMP) ? S_DUMP : S_DEL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.link    = 1'b1;
                cmd.respond = 1'b1;
                state_next  = S_RESP;
            end
            S_DEL:
            begin
                cmd.del     = 1'b1;
                cmd.respond = 1'b1;
                state_next  = S_RESP;
            end
            S_DUMP:
            begin
                cmd.emit   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    // advance the dump walk unless this was the final word
                    cmd.rd_sel = RD_WALK;
                    state_next = stat.last ? S_IDLE : S_DUMP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Never take a request while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while result pending");

    // The final result of an item frees the block for the next one
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && stat.last |=> req_ready)
        else $error("block not idle after final result");

    // A result word that is not the final one continues the dump walk
    a_more_dump: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !stat.last |=> state_reg == S_DUMP)
        else $error("dump walk did not continue");

endmodule
